### rtl/hart_request_frame_checker_core_assert.svh
// Assertion macros for the request frame checker.
// Expects clk and rst_n in the scope of use; no other dependencies.
`ifndef HART_REQUEST_FRAME_CHECKER_CORE_ASSERT_SVH
`define HART_REQUEST_FRAME_CHECKER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define HRFC_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hrfc check failed");

// Next-cycle implication, disabled during reset.
`define HRFC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hrfc check failed");

`endif

### rtl/hrfc_pkg.sv
// Shared types and constants for the request frame checker.
// No dependencies.
package hrfc_pkg;

  localparam logic [7:0] SHORT_DELIM = 8'h02;
  localparam logic [7:0] LONG_DELIM  = 8'h82;
  localparam logic [5:0] ADDR_MASK   = 6'h3F;

  localparam logic [8:0] SHORT_CMD_POS = 9'd2;
  localparam logic [8:0] LONG_CMD_POS  = 9'd6;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_DELIM = 2'd1,
    ST_CHECKSUM  = 2'd2,
    ST_ADDR_MISS = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_POLL_ADDR = 2'd0,
    REG_MFR_CODE  = 2'd1,
    REG_DEV_TYPE  = 2'd2,
    REG_DEV_SER   = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] command;
    logic       long_frame;
    logic [7:0] byte_count;
  } out_item_t;

  typedef struct packed {
    logic [5:0]  polling_address;
    logic [5:0]  manufacturer_code;
    logic [7:0]  device_type_code;
    logic [23:0] device_serial;
  } cfg_t;

  typedef struct packed {
    logic       in_frame;
    logic       is_long;
    logic [8:0] position;
  } frame_stat_t;

endpackage

### rtl/hrfc_in_stage.sv
// Input register stage of the request frame checker.
// Depends on hrfc_pkg.
module hrfc_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  hrfc_pkg::in_item_t in_data,
  input  logic              advance,
  output logic              s1_valid,
  output hrfc_pkg::in_item_t s1_data
);
  import hrfc_pkg::*;

  logic     s1_valid_r, s1_valid_nxt;
  in_item_t s1_data_r;
  logic     accept;

  assign in_stall = s1_valid_r && !advance;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_data_r <= in_data;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_data  = s1_data_r;

endmodule

### rtl/hrfc_frame.sv
// Frame tracking state and per-byte checking logic.
// Depends on hrfc_pkg.
module hrfc_frame (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  hrfc_pkg::in_item_t    item,
  input  hrfc_pkg::cfg_t        cfg,
  output logic                  res_valid,
  output hrfc_pkg::out_item_t   res,
  output hrfc_pkg::frame_stat_t stat
);
  import hrfc_pkg::*;

  logic       in_frame_r, in_frame_nxt;
  logic [8:0] pos_r, pos_nxt;
  logic [7:0] xor_r, xor_nxt;
  logic       is_long_r, is_long_nxt;
  logic       match_r, match_nxt;
  logic [7:0] cmd_r, cmd_nxt;
  logic [7:0] cnt_r, cnt_nxt;

  logic [8:0] cmd_pos;
  logic [8:0] chk_pos;
  logic       is_chk;
  logic       byte_ok;
  logic [7:0] b;

  assign b       = item.rx_byte;
  assign cmd_pos = is_long_r ? LONG_CMD_POS : SHORT_CMD_POS;
  assign chk_pos = cmd_pos + 9'd2 + {1'b0, cnt_r};
  assign is_chk  = (pos_r > (cmd_pos + 9'd1)) && (pos_r == chk_pos);

  // address byte compare for the current position
  always_comb begin
    byte_ok = 1'b1;
    if (is_long_r) begin
      case (pos_r)
        9'd1:    byte_ok = (b[5:0] & ADDR_MASK) == cfg.manufacturer_code;
        9'd2:    byte_ok = b == cfg.device_type_code;
        9'd3:    byte_ok = b == cfg.device_serial[23:16];
        9'd4:    byte_ok = b == cfg.device_serial[15:8];
        9'd5:    byte_ok = b == cfg.device_serial[7:0];
        default: byte_ok = 1'b1;
      endcase
    end else if (pos_r == 9'd1) begin
      byte_ok = (b[5:0] & ADDR_MASK) == cfg.polling_address;
    end
  end

  always_comb begin
    in_frame_nxt = in_frame_r;
    pos_nxt      = pos_r;
    xor_nxt      = xor_r;
    is_long_nxt  = is_long_r;
    match_nxt    = match_r;
    cmd_nxt      = cmd_r;
    cnt_nxt      = cnt_r;
    res_valid    = 1'b0;
    res.status     = ST_OK;
    res.command    = cmd_r;
    res.long_frame = is_long_r;
    res.byte_count = cnt_r;

    if (step) begin
      if (item.frame_start) begin
        in_frame_nxt = 1'b0;
        pos_nxt      = 9'd0;
        xor_nxt      = 8'd0;
        is_long_nxt  = 1'b0;
        match_nxt    = 1'b1;
        cmd_nxt      = 8'd0;
        cnt_nxt      = 8'd0;
        if (b == SHORT_DELIM || b == LONG_DELIM) begin
          in_frame_nxt = 1'b1;
          is_long_nxt  = (b == LONG_DELIM);
          pos_nxt      = 9'd1;
          xor_nxt      = b;
        end else begin
          res_valid      = 1'b1;
          res.status     = ST_BAD_DELIM;
          res.command    = 8'd0;
          res.long_frame = 1'b0;
          res.byte_count = 8'd0;
        end
      end else if (in_frame_r) begin
        if (is_chk) begin
          res_valid    = 1'b1;
          // address mismatch takes priority over checksum
          res.status   = !match_r ? ST_ADDR_MISS : (b == xor_r ? ST_OK : ST_CHECKSUM);
          in_frame_nxt = 1'b0;
          pos_nxt      = 9'd0;
        end else begin
          if (!byte_ok) begin
            match_nxt = 1'b0;
          end
          if (pos_r == cmd_pos) begin
            cmd_nxt = b;
          end
          if (pos_r == cmd_pos + 9'd1) begin
            cnt_nxt = b;
          end
          xor_nxt = xor_r ^ b;
          pos_nxt = pos_r + 9'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      pos_r      <= 9'd0;
      xor_r      <= 8'd0;
      is_long_r  <= 1'b0;
      match_r    <= 1'b1;
      cmd_r      <= 8'd0;
      cnt_r      <= 8'd0;
    end else begin
      in_frame_r <= in_frame_nxt;
      pos_r      <= pos_nxt;
      xor_r      <= xor_nxt;
      is_long_r  <= is_long_nxt;
      match_r    <= match_nxt;
      cmd_r      <= cmd_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

  assign stat.in_frame = in_frame_r;
  assign stat.is_long  = is_long_r;
  assign stat.position = pos_r;

endmodule

### rtl/hrfc_out_reg.sv
// Result output register with valid/stall handshake.
// Depends on hrfc_pkg.
module hrfc_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                res_valid,
  input  hrfc_pkg::out_item_t res,
  output logic                ready,
  output logic                out_valid,
  input  logic                out_stall,
  output hrfc_pkg::out_item_t out_data
);
  import hrfc_pkg::*;

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r;

  // slot is free when empty or when the held result transfers this cycle
  assign ready = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ready) begin
      out_valid_nxt = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### rtl/hart_request_frame_checker_core.sv
// Request frame checker: each input byte is registered in the input stage, and its result in the result register.
// Throughput one byte per cycle; stalls only when the result register is held.
// Path: input register -> per-byte frame logic -> result register.
// Reset (rst_n low, synchronous): hunting for a delimiter, config registers zero.
// Depends on hrfc_pkg, hrfc_in_stage, hrfc_frame, hrfc_out_reg and the assert header.
`include "hart_request_frame_checker_core_assert.svh"

module hart_request_frame_checker_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  hrfc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output hrfc_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  hrfc_pkg::reg_idx_t  cfg_index,
  input  logic [23:0]         cfg_wdata
);
  import hrfc_pkg::*;

  cfg_t        cfg_r;
  logic        s1_valid;
  in_item_t    s1_data;
  logic        ready;
  logic        step;
  logic        res_valid;
  out_item_t   res;
  frame_stat_t stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_POLL_ADDR: cfg_r.polling_address   <= cfg_wdata[5:0];
        REG_MFR_CODE:  cfg_r.manufacturer_code <= cfg_wdata[5:0];
        REG_DEV_TYPE:  cfg_r.device_type_code  <= cfg_wdata[7:0];
        REG_DEV_SER:   cfg_r.device_serial     <= cfg_wdata;
        default:       cfg_r <= cfg_r;
      endcase
    end
  end

  assign step = s1_valid && ready;

  hrfc_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .advance  (ready),
    .s1_valid (s1_valid),
    .s1_data  (s1_data)
  );

  hrfc_frame u_frame (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .item      (s1_data),
    .cfg       (cfg_r),
    .res_valid (res_valid),
    .res       (res),
    .stat      (stat)
  );

  hrfc_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .ready     (ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  `HRFC_ASSERT_IMPLY(a_bad_delim_fields, out_valid && out_data.status == ST_BAD_DELIM,
    out_data.command == 8'd0 && !out_data.long_frame && out_data.byte_count == 8'd0)
  `HRFC_ASSERT_IMPLY(a_hunt_pos_zero, !stat.in_frame, stat.position == 9'd0)
  `HRFC_ASSERT_IMPLY(a_frame_pos_nonzero, stat.in_frame, stat.position != 9'd0)
  `HRFC_ASSERT_IMPLY(a_stall_needs_item, in_stall, s1_valid && out_valid && out_stall)
  `HRFC_ASSERT_NEXT(a_result_from_step, res_valid && ready, out_valid)

endmodule
